// ----- sv/planar_point_arc_transform_assert.svh -----
// Assertion helpers; expect clk and rst_n in scope.
`ifndef PLANAR_POINT_ARC_TRANSFORM_ASSERT_SVH
`define PLANAR_POINT_ARC_TRANSFORM_ASSERT_SVH

// same-cycle implication
`define PAT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: implication check failed");

// next-cycle implication
`define PAT_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

// ----- sv/pat_pkg.sv -----
package pat_pkg;

  localparam int COORD_FRAC_BITS   = 16;
  localparam int CORDIC_STAGES_DEF = 24;
  localparam int MAX_STAGES        = 30;

  // vectoring input, vectoring datapath, trig, operand, product, rounded product widths
  localparam int VIN_W = 34;
  localparam int VCW   = 38;
  localparam int TW    = 33;
  localparam int AW    = 33;
  localparam int PW    = 66;
  localparam int MW    = 36;

  localparam logic signed [TW-1:0] INV_GAIN  = 33'sd652032874;
  localparam logic signed [31:0]   HALF_TURN = 32'sh2000_0000;
  localparam logic [63:0] AXIS_RESET = 64'd1 << (32 + COORD_FRAC_BITS);

  typedef enum logic [1:0] {
    FUNC_TRANSLATE = 2'd0,
    FUNC_ROTATE    = 2'd1,
    FUNC_MIRROR    = 2'd2,
    FUNC_STRETCH   = 2'd3
  } func_t;

  localparam logic KIND_POINT = 1'b0;
  localparam logic KIND_ARC   = 1'b1;

  typedef enum logic [2:0] {
    CFG_SHIFT    = 3'd0,
    CFG_PIVOT    = 3'd1,
    CFG_TURN     = 3'd2,
    CFG_AXIS     = 3'd3,
    CFG_BOX_LO   = 3'd4,
    CFG_BOX_HI   = 3'd5,
    CFG_DEGEN    = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    func_t              func;
    logic               elem_kind;
    logic signed [31:0] in_x;
    logic signed [31:0] in_y;
    logic [30:0]        in_radius;
    logic [29:0]        in_start_angle;
    logic signed [31:0] in_sweep;
  } in_item_t;

  typedef struct packed {
    logic               out_kind;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic [30:0]        out_radius;
    logic [29:0]        out_start_angle;
    logic signed [31:0] out_sweep;
  } out_item_t;

  // context carried down the pipeline, filled in stage by stage
  typedef struct packed {
    func_t              func;
    logic               kind;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic [30:0]        rad;
    logic [29:0]        st;
    logic signed [31:0] sw;
    logic [29:0]        twice;
    logic signed [AW-1:0] a;
    logic signed [AW-1:0] b;
    logic signed [31:0] ox;
    logic signed [31:0] oy;
    logic signed [31:0] spx;
    logic signed [31:0] spy;
    logic signed [31:0] mx;
    logic signed [31:0] my;
    logic               inbox;
    logic               upd;
  } ctx_t;

  function automatic logic [27:0] atan_val(input int i);
    logic [27:0] v;
    case (i)
      0:  v = 28'd134217728;
      1:  v = 28'd79233351;
      2:  v = 28'd41864727;
      3:  v = 28'd21251189;
      4:  v = 28'd10666833;
      5:  v = 28'd5338616;
      6:  v = 28'd2669960;
      7:  v = 28'd1335061;
      8:  v = 28'd667541;
      9:  v = 28'd333772;
      10: v = 28'd166886;
      11: v = 28'd83443;
      12: v = 28'd41722;
      13: v = 28'd20861;
      14: v = 28'd10430;
      15: v = 28'd5215;
      16: v = 28'd2608;
      17: v = 28'd1304;
      18: v = 28'd652;
      19: v = 28'd326;
      20: v = 28'd163;
      21: v = 28'd81;
      22: v = 28'd41;
      23: v = 28'd20;
      24: v = 28'd10;
      25: v = 28'd5;
      26: v = 28'd3;
      27: v = 28'd1;
      28: v = 28'd1;
      default: v = 28'd0;
    endcase
    return v;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
    logic signed [31:0] r;
    if (v > 40'sd2147483647)       r = 32'sh7fff_ffff;
    else if (v < -40'sd2147483648) r = 32'sh8000_0000;
    else                           r = v[31:0];
    return r;
  endfunction

endpackage

// ----- sv/pat_stream_if.sv -----
interface pat_stream_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- sv/pat_delay.sv -----
module pat_delay #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         en,
  input  logic         in_valid,
  input  logic [W-1:0] in_data,
  output logic         out_valid,
  output logic [W-1:0] out_data
);

  logic [DEPTH-1:0] valid_r;
  logic [W-1:0]     data_r [DEPTH];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (en) begin
      for (int i = DEPTH - 1; i > 0; i--) valid_r[i] <= valid_r[i-1];
      valid_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = DEPTH - 1; i > 0; i--) data_r[i] <= data_r[i-1];
      data_r[0] <= in_data;
    end
  end

  assign out_valid = valid_r[DEPTH-1];
  assign out_data  = data_r[DEPTH-1];

endmodule

// ----- sv/pat_rotate.sv -----
module pat_rotate #(
  parameter int STAGES = 24
) (
  input  logic                            clk,
  input  logic                            en,
  input  logic [29:0]                     ang_i,
  output logic signed [pat_pkg::TW-1:0]   cos_o,
  output logic signed [pat_pkg::TW-1:0]   sin_o
);

  localparam int TW = pat_pkg::TW;

  logic signed [TW-1:0] x_r [STAGES+1];
  logic signed [TW-1:0] y_r [STAGES+1];
  logic signed [31:0]   z_r [STAGES+1];
  logic [1:0]           q_r [STAGES+1];
  logic signed [TW-1:0] x_nxt [STAGES+1];
  logic signed [TW-1:0] y_nxt [STAGES+1];
  logic signed [31:0]   z_nxt [STAGES+1];
  logic [1:0]           q_nxt [STAGES+1];
  logic signed [TW-1:0] cos_r, sin_r, cos_nxt, sin_nxt;

  always_comb begin
    x_nxt[0] = pat_pkg::INV_GAIN;
    y_nxt[0] = '0;
    z_nxt[0] = $signed({4'b0000, ang_i[27:0]});
    q_nxt[0] = ang_i[29:28];
    for (int i = 0; i < STAGES; i++) begin
      q_nxt[i+1] = q_r[i];
      if (!z_r[i][31]) begin
        x_nxt[i+1] = x_r[i] - (y_r[i] >>> i);
        y_nxt[i+1] = y_r[i] + (x_r[i] >>> i);
        z_nxt[i+1] = z_r[i] - $signed({4'b0000, pat_pkg::atan_val(i)});
      end else begin
        x_nxt[i+1] = x_r[i] + (y_r[i] >>> i);
        y_nxt[i+1] = y_r[i] - (x_r[i] >>> i);
        z_nxt[i+1] = z_r[i] + $signed({4'b0000, pat_pkg::atan_val(i)});
      end
    end
  end

  // fold back to the quadrant taken off the angle
  always_comb begin
    case (q_r[STAGES])
      2'd0: begin cos_nxt = x_r[STAGES];  sin_nxt = y_r[STAGES];  end
      2'd1: begin cos_nxt = -y_r[STAGES]; sin_nxt = x_r[STAGES];  end
      2'd2: begin cos_nxt = -x_r[STAGES]; sin_nxt = -y_r[STAGES]; end
      default: begin cos_nxt = y_r[STAGES]; sin_nxt = -x_r[STAGES]; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i <= STAGES; i++) begin
        x_r[i] <= x_nxt[i];
        y_r[i] <= y_nxt[i];
        z_r[i] <= z_nxt[i];
        q_r[i] <= q_nxt[i];
      end
      cos_r <= cos_nxt;
      sin_r <= sin_nxt;
    end
  end

  assign cos_o = cos_r;
  assign sin_o = sin_r;

endmodule

// ----- sv/pat_vector.sv -----
module pat_vector #(
  parameter int STAGES = 24
) (
  input  logic                              clk,
  input  logic                              en,
  input  logic signed [pat_pkg::VIN_W-1:0]  x_i,
  input  logic signed [pat_pkg::VIN_W-1:0]  y_i,
  output logic [29:0]                       ang_o
);

  localparam int VCW   = pat_pkg::VCW;
  localparam int NORM  = 5;
  localparam int L     = 1 + NORM + STAGES;

  logic signed [VCW-1:0] x_r [L];
  logic signed [VCW-1:0] y_r [L];
  logic signed [31:0]    z_r [L];
  logic                  zero_r [L];
  logic signed [VCW-1:0] x_nxt [L];
  logic signed [VCW-1:0] y_nxt [L];
  logic signed [31:0]    z_nxt [L];
  logic                  zero_nxt [L];

  always_comb begin
    logic signed [VCW-1:0] xe, ye, mag, m;
    int s;
    xe = VCW'(x_i);
    ye = VCW'(y_i);
    zero_nxt[0] = (x_i == '0) && (y_i == '0);
    if (x_i[pat_pkg::VIN_W-1]) begin
      x_nxt[0] = -xe;
      y_nxt[0] = -ye;
      z_nxt[0] = pat_pkg::HALF_TURN;
    end else begin
      x_nxt[0] = xe;
      y_nxt[0] = ye;
      z_nxt[0] = '0;
    end
    // scale up until the larger component reaches 2^30: shifts of 16, 8, 4, 2, 1
    for (int k = 0; k < NORM; k++) begin
      s   = 16 >> k;
      mag = y_r[k][VCW-1] ? -y_r[k] : y_r[k];
      m   = (x_r[k] > mag) ? x_r[k] : mag;
      zero_nxt[k+1] = zero_r[k];
      z_nxt[k+1]    = z_r[k];
      if (m < (VCW'(1) <<< (31 - s))) begin
        x_nxt[k+1] = x_r[k] <<< s;
        y_nxt[k+1] = y_r[k] <<< s;
      end else begin
        x_nxt[k+1] = x_r[k];
        y_nxt[k+1] = y_r[k];
      end
    end
    for (int i = 0; i < STAGES; i++) begin
      zero_nxt[NORM+1+i] = zero_r[NORM+i];
      if (y_r[NORM+i][VCW-1]) begin
        x_nxt[NORM+1+i] = x_r[NORM+i] - (y_r[NORM+i] >>> i);
        y_nxt[NORM+1+i] = y_r[NORM+i] + (x_r[NORM+i] >>> i);
        z_nxt[NORM+1+i] = z_r[NORM+i] - $signed({4'b0000, pat_pkg::atan_val(i)});
      end else begin
        x_nxt[NORM+1+i] = x_r[NORM+i] + (y_r[NORM+i] >>> i);
        y_nxt[NORM+1+i] = y_r[NORM+i] - (x_r[NORM+i] >>> i);
        z_nxt[NORM+1+i] = z_r[NORM+i] + $signed({4'b0000, pat_pkg::atan_val(i)});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < L; j++) begin
        x_r[j]    <= x_nxt[j];
        y_r[j]    <= y_nxt[j];
        z_r[j]    <= z_nxt[j];
        zero_r[j] <= zero_nxt[j];
      end
    end
  end

  assign ang_o = zero_r[L-1] ? 30'd0 : z_r[L-1][29:0];

endmodule

// ----- sv/planar_point_arc_transform.sv -----
// Planar point/arc transform: translate, rotate about a pivot, mirror across a line
// or stretch within a box, on one point or arc per transaction. A new element is
// taken every cycle unless the output stalls; results come out in order after the
// axis-angle vectoring CORDIC, the sine/cosine CORDIC and the start-angle vectoring
// CORDIC in series. The whole pipeline holds while a result waits on the output, so
// in_s.ready follows out_s.ready. Registers must be written by the user through
// cfg_we/cfg_index/cfg_data only while no element is in flight (not enforced).
`include "planar_point_arc_transform_assert.svh"

module planar_point_arc_transform #(
  parameter int CORDIC_STAGES = pat_pkg::CORDIC_STAGES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  pat_stream_if.sink   in_s,
  pat_stream_if.source out_s,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  localparam int N     = (CORDIC_STAGES > pat_pkg::MAX_STAGES) ? pat_pkg::MAX_STAGES
                                                                : CORDIC_STAGES;
  localparam int LV    = 6 + N;
  localparam int LR    = N + 2;
  localparam int CW    = $bits(pat_pkg::ctx_t);
  localparam int VIN_W = pat_pkg::VIN_W;
  localparam int TW    = pat_pkg::TW;
  localparam int AW    = pat_pkg::AW;
  localparam int PW    = pat_pkg::PW;
  localparam int MW    = pat_pkg::MW;

  // ---------------- configuration ----------------
  logic [63:0] shift_r, pivot_r, axis_r, box_lo_r, box_hi_r;
  logic [29:0] turn_r;
  logic [31:0] degen_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_r  <= '0;
      pivot_r  <= '0;
      turn_r   <= '0;
      axis_r   <= pat_pkg::AXIS_RESET;
      box_lo_r <= '0;
      box_hi_r <= '0;
      degen_r  <= 32'd1;
    end else if (cfg_we) begin
      case (pat_pkg::cfg_idx_t'(cfg_index))
        pat_pkg::CFG_SHIFT:  shift_r  <= cfg_data;
        pat_pkg::CFG_PIVOT:  pivot_r  <= cfg_data;
        pat_pkg::CFG_TURN:   turn_r   <= cfg_data[29:0];
        pat_pkg::CFG_AXIS:   axis_r   <= cfg_data;
        pat_pkg::CFG_BOX_LO: box_lo_r <= cfg_data;
        pat_pkg::CFG_BOX_HI: box_hi_r <= cfg_data;
        pat_pkg::CFG_DEGEN:  degen_r  <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  logic signed [31:0] sxv, syv, pxv, pyv, ddx, ddy, blx, bly, bhx, bhy;
  assign sxv = shift_r[63:32];
  assign syv = shift_r[31:0];
  assign pxv = pivot_r[63:32];
  assign pyv = pivot_r[31:0];
  assign ddx = axis_r[63:32];
  assign ddy = axis_r[31:0];
  assign blx = box_lo_r[63:32];
  assign bly = box_lo_r[31:0];
  assign bhx = box_hi_r[63:32];
  assign bhy = box_hi_r[31:0];

  // squared axis length; settles long before an element reaches the mirror select
  logic signed [63:0] sq_x, sq_y;
  logic [63:0] lsq_xx_r, lsq_yy_r;
  logic        lsq_gt_r;
  assign sq_x = ddx * ddx;
  assign sq_y = ddy * ddy;
  always_ff @(posedge clk) begin
    lsq_xx_r <= sq_x;
    lsq_yy_r <= sq_y;
    lsq_gt_r <= (lsq_xx_r + lsq_yy_r) > 64'(degen_r);
  end

  function automatic logic in_box(input logic signed [31:0] x, input logic signed [31:0] y,
                                  input logic signed [31:0] lx, input logic signed [31:0] hx,
                                  input logic signed [31:0] ly, input logic signed [31:0] hy);
    return (x >= lx) && (x <= hx) && (y >= ly) && (y <= hy);
  endfunction

  function automatic logic signed [MW-1:0] round_q30(input logic signed [PW-1:0] p);
    logic signed [PW-1:0] t;
    t = p + $signed({{(PW-30){1'b0}}, 1'b1, 29'b0});
    return MW'(t >>> 30);
  endfunction

  // ---------------- handshake ----------------
  logic                en;
  logic                out_valid_r;
  pat_pkg::out_item_t  out_data_r;

  assign en        = !out_valid_r || out_s.ready;
  assign in_s.ready = en;
  assign out_s.valid = out_valid_r;
  assign out_s.data  = out_data_r;

  // ---------------- input stage ----------------
  logic          s0_valid_r;
  pat_pkg::ctx_t s0_ctx_r, s0_ctx_nxt;

  always_comb begin
    s0_ctx_nxt      = '0;
    s0_ctx_nxt.func = in_s.data.func;
    s0_ctx_nxt.kind = in_s.data.elem_kind;
    s0_ctx_nxt.x    = in_s.data.in_x;
    s0_ctx_nxt.y    = in_s.data.in_y;
    s0_ctx_nxt.rad  = in_s.data.in_radius;
    s0_ctx_nxt.st   = in_s.data.in_start_angle;
    s0_ctx_nxt.sw   = in_s.data.in_sweep;
  end

  always_ff @(posedge clk) begin
    if (!rst_n)  s0_valid_r <= 1'b0;
    else if (en) s0_valid_r <= in_s.valid;
  end
  always_ff @(posedge clk) begin
    if (en) s0_ctx_r <= s0_ctx_nxt;
  end

  // ---------------- mirror axis angle ----------------
  logic [29:0]   v1_ang;
  logic          d1_valid;
  logic [CW-1:0] d1_bits;
  pat_pkg::ctx_t d1_ctx;

  pat_vector #(.STAGES(N)) u_axis_vec (
    .clk(clk), .en(en), .x_i(VIN_W'(ddx)), .y_i(VIN_W'(ddy)), .ang_o(v1_ang)
  );

  pat_delay #(.W(CW), .DEPTH(LV)) u_dly_axis (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(s0_valid_r), .in_data(s0_ctx_r),
    .out_valid(d1_valid), .out_data(d1_bits)
  );
  assign d1_ctx = pat_pkg::ctx_t'(d1_bits);

  // ---------------- angle and operand select ----------------
  logic          c_valid_r;
  pat_pkg::ctx_t c_ctx_r, c_ctx_nxt;
  logic [29:0]   c_ang_r, c_ang_nxt;

  always_comb begin
    c_ctx_nxt       = d1_ctx;
    c_ctx_nxt.twice = {v1_ang[28:0], 1'b0};
    if (d1_ctx.func == pat_pkg::FUNC_STRETCH) begin
      c_ctx_nxt.a = AW'($signed({1'b0, d1_ctx.rad}));
      c_ctx_nxt.b = '0;
    end else begin
      c_ctx_nxt.a = AW'(d1_ctx.x) - AW'(pxv);
      c_ctx_nxt.b = AW'(d1_ctx.y) - AW'(pyv);
    end
    case (d1_ctx.func)
      pat_pkg::FUNC_ROTATE: c_ang_nxt = turn_r;
      pat_pkg::FUNC_MIRROR: c_ang_nxt = {v1_ang[28:0], 1'b0};
      default:              c_ang_nxt = d1_ctx.st;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n)  c_valid_r <= 1'b0;
    else if (en) c_valid_r <= d1_valid;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      c_ctx_r <= c_ctx_nxt;
      c_ang_r <= c_ang_nxt;
    end
  end

  // ---------------- sine / cosine ----------------
  logic signed [TW-1:0] r_cos, r_sin;
  logic          d2_valid;
  logic [CW-1:0] d2_bits;
  pat_pkg::ctx_t d2_ctx;

  pat_rotate #(.STAGES(N)) u_trig (
    .clk(clk), .en(en), .ang_i(c_ang_r), .cos_o(r_cos), .sin_o(r_sin)
  );

  pat_delay #(.W(CW), .DEPTH(LR)) u_dly_trig (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(c_valid_r), .in_data(c_ctx_r),
    .out_valid(d2_valid), .out_data(d2_bits)
  );
  assign d2_ctx = pat_pkg::ctx_t'(d2_bits);

  // ---------------- products ----------------
  logic          e_valid_r;
  pat_pkg::ctx_t e_ctx_r;
  logic signed [PW-1:0] e_p1_r, e_p2_r, e_p3_r, e_p4_r;

  always_ff @(posedge clk) begin
    if (!rst_n)  e_valid_r <= 1'b0;
    else if (en) e_valid_r <= d2_valid;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      e_ctx_r <= d2_ctx;
      e_p1_r  <= PW'(d2_ctx.a) * PW'(r_cos);
      e_p2_r  <= PW'(d2_ctx.b) * PW'(r_sin);
      e_p3_r  <= PW'(d2_ctx.a) * PW'(r_sin);
      e_p4_r  <= PW'(d2_ctx.b) * PW'(r_cos);
    end
  end

  // ---------------- rounding ----------------
  logic          f_valid_r;
  pat_pkg::ctx_t f_ctx_r;
  logic signed [MW-1:0] f_m1_r, f_m2_r, f_m3_r, f_m4_r;

  always_ff @(posedge clk) begin
    if (!rst_n)  f_valid_r <= 1'b0;
    else if (en) f_valid_r <= e_valid_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      f_ctx_r <= e_ctx_r;
      f_m1_r  <= round_q30(e_p1_r);
      f_m2_r  <= round_q30(e_p2_r);
      f_m3_r  <= round_q30(e_p3_r);
      f_m4_r  <= round_q30(e_p4_r);
    end
  end

  // ---------------- coordinate results ----------------
  logic          g_valid_r;
  pat_pkg::ctx_t g_ctx_r, g_ctx_nxt;

  always_comb begin
    logic signed [39:0] xe, ye, m1e, m2e, m3e, m4e;
    xe  = 40'(f_ctx_r.x);
    ye  = 40'(f_ctx_r.y);
    m1e = 40'(f_m1_r);
    m2e = 40'(f_m2_r);
    m3e = 40'(f_m3_r);
    m4e = 40'(f_m4_r);
    g_ctx_nxt    = f_ctx_r;
    g_ctx_nxt.ox = f_ctx_r.x;
    g_ctx_nxt.oy = f_ctx_r.y;
    case (f_ctx_r.func)
      pat_pkg::FUNC_TRANSLATE: begin
        g_ctx_nxt.ox = pat_pkg::sat32(xe + 40'(sxv));
        g_ctx_nxt.oy = pat_pkg::sat32(ye + 40'(syv));
      end
      pat_pkg::FUNC_ROTATE: begin
        g_ctx_nxt.ox = pat_pkg::sat32(40'(pxv) + m1e - m2e);
        g_ctx_nxt.oy = pat_pkg::sat32(40'(pyv) + m3e + m4e);
        g_ctx_nxt.st = f_ctx_r.st + turn_r;
      end
      pat_pkg::FUNC_MIRROR: begin
        // a near-zero axis leaves the coordinates alone
        if (lsq_gt_r) begin
          g_ctx_nxt.ox = pat_pkg::sat32(40'(pxv) + m1e + m2e);
          g_ctx_nxt.oy = pat_pkg::sat32(40'(pyv) + m3e - m4e);
        end
        g_ctx_nxt.st = f_ctx_r.twice - f_ctx_r.st;
        g_ctx_nxt.sw = -f_ctx_r.sw;
      end
      default: begin
        if (f_ctx_r.kind == pat_pkg::KIND_POINT) begin
          if (in_box(f_ctx_r.x, f_ctx_r.y, blx, bhx, bly, bhy)) begin
            g_ctx_nxt.ox = pat_pkg::sat32(xe + 40'(sxv));
            g_ctx_nxt.oy = pat_pkg::sat32(ye + 40'(syv));
          end
        end else begin
          // arc start point on the circle
          g_ctx_nxt.spx = pat_pkg::sat32(xe + m1e);
          g_ctx_nxt.spy = pat_pkg::sat32(ye + m3e);
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n)  g_valid_r <= 1'b0;
    else if (en) g_valid_r <= f_valid_r;
  end
  always_ff @(posedge clk) begin
    if (en) g_ctx_r <= g_ctx_nxt;
  end

  // ---------------- arc stretch: shifted start point ----------------
  logic          h_valid_r;
  pat_pkg::ctx_t h_ctx_r, h_ctx_nxt;

  always_comb begin
    h_ctx_nxt       = g_ctx_r;
    h_ctx_nxt.inbox = in_box(g_ctx_r.spx, g_ctx_r.spy, blx, bhx, bly, bhy);
    h_ctx_nxt.mx    = pat_pkg::sat32(40'(g_ctx_r.spx) + 40'(sxv));
    h_ctx_nxt.my    = pat_pkg::sat32(40'(g_ctx_r.spy) + 40'(syv));
  end

  always_ff @(posedge clk) begin
    if (!rst_n)  h_valid_r <= 1'b0;
    else if (en) h_valid_r <= g_valid_r;
  end
  always_ff @(posedge clk) begin
    if (en) h_ctx_r <= h_ctx_nxt;
  end

  logic          i_valid_r;
  pat_pkg::ctx_t i_ctx_r, i_ctx_nxt;
  logic signed [VIN_W-1:0] i_dvx_r, i_dvy_r;

  always_comb begin
    i_ctx_nxt     = h_ctx_r;
    i_ctx_nxt.upd = (h_ctx_r.func == pat_pkg::FUNC_STRETCH) &&
                    (h_ctx_r.kind == pat_pkg::KIND_ARC) && h_ctx_r.inbox &&
                    ((h_ctx_r.mx != h_ctx_r.spx) || (h_ctx_r.my != h_ctx_r.spy));
  end

  always_ff @(posedge clk) begin
    if (!rst_n)  i_valid_r <= 1'b0;
    else if (en) i_valid_r <= h_valid_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      i_ctx_r <= i_ctx_nxt;
      i_dvx_r <= VIN_W'(h_ctx_r.mx) - VIN_W'(h_ctx_r.x);
      i_dvy_r <= VIN_W'(h_ctx_r.my) - VIN_W'(h_ctx_r.y);
    end
  end

  // ---------------- new start angle ----------------
  logic [29:0]   v2_ang;
  logic          d3_valid;
  logic [CW-1:0] d3_bits;
  pat_pkg::ctx_t d3_ctx;

  pat_vector #(.STAGES(N)) u_start_vec (
    .clk(clk), .en(en), .x_i(i_dvx_r), .y_i(i_dvy_r), .ang_o(v2_ang)
  );

  pat_delay #(.W(CW), .DEPTH(LV)) u_dly_start (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(i_valid_r), .in_data(i_ctx_r),
    .out_valid(d3_valid), .out_data(d3_bits)
  );
  assign d3_ctx = pat_pkg::ctx_t'(d3_bits);

  // ---------------- output register ----------------
  pat_pkg::out_item_t out_data_nxt;

  always_comb begin
    out_data_nxt.out_kind = d3_ctx.kind;
    out_data_nxt.out_x    = d3_ctx.ox;
    out_data_nxt.out_y    = d3_ctx.oy;
    if (d3_ctx.kind == pat_pkg::KIND_POINT) begin
      out_data_nxt.out_radius      = '0;
      out_data_nxt.out_start_angle = '0;
      out_data_nxt.out_sweep       = '0;
    end else begin
      out_data_nxt.out_radius      = d3_ctx.rad;
      out_data_nxt.out_start_angle = d3_ctx.upd ? v2_ang : d3_ctx.st;
      out_data_nxt.out_sweep       = d3_ctx.sw;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n)  out_valid_r <= 1'b0;
    else if (en) out_valid_r <= d3_valid;
  end
  always_ff @(posedge clk) begin
    if (en) out_data_r <= out_data_nxt;
  end

  // ---------------- checks ----------------
  `PAT_ASSERT_IMP(a_point_fields_zero, out_valid_r && (out_data_r.out_kind == pat_pkg::KIND_POINT), (out_data_r.out_radius == '0) && (out_data_r.out_start_angle == '0) && (out_data_r.out_sweep == '0))
  `PAT_ASSERT_NXT(a_stall_freezes_pipe, out_valid_r && !out_s.ready, $stable(s0_valid_r) && $stable(c_valid_r) && $stable(i_valid_r))
  `PAT_ASSERT_NXT(a_accept_enters, in_s.valid && in_s.ready, s0_valid_r)

endmodule

// ----- sim/pat_transform_checker.sv -----
`timescale 1ns / 100ps

module pat_transform_checker
  import pat_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  pat_stream_if       in_mon,
  pat_stream_if       out_mon,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  output int          outstanding,
  output int          fail_count,
  output int          results_seen
);

  localparam int STAGES = CORDIC_STAGES_DEF;

  // arctan(2^-i) in turn units of 2^30
  localparam longint ATAN_STEP [30] = '{
    134217728, 79233351, 41864727, 21251189, 10666833, 5338616, 2669960,
    1335061, 667541, 333772, 166886, 83443, 41722, 20861, 10430, 5215,
    2608, 1304, 652, 326, 163, 81, 41, 20, 10, 5, 3, 1, 1, 0
  };

  logic [63:0] shift_r, pivot_r, axis_r, box_lo_r, box_hi_r;
  logic [29:0] turn_r;
  logic [31:0] degen_r;

  out_item_t expected_q[$];

  function automatic logic signed [31:0] clamp32(input longint v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647)       r = 32'sh7fff_ffff;
    else if (v < -64'sd2147483648) r = 32'sh8000_0000;
    else                           r = v[31:0];
    return r;
  endfunction

  function automatic longint hi_half(input logic [63:0] v);
    longint r;
    r = $signed(v[63:32]);
    return r;
  endfunction

  function automatic longint lo_half(input logic [63:0] v);
    longint r;
    r = $signed(v[31:0]);
    return r;
  endfunction

  // coordinate times Q2.30 trig, rounded half up
  function automatic longint scale_trig(input longint a, input longint t);
    return (a * t + 64'sd536870912) >>> 30;
  endfunction

  function automatic void rotate_unit(input logic [29:0] ang, output longint c,
                                      output longint s);
    longint x, y, z, nx;
    x = 652032874;
    y = 0;
    z = longint'(ang[27:0]);
    for (int i = 0; i < STAGES; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i); y = y + (x >>> i); z = z - ATAN_STEP[i];
      end else begin
        nx = x + (y >>> i); y = y - (x >>> i); z = z + ATAN_STEP[i];
      end
      x = nx;
    end
    case (ang[29:28])
      2'd0: begin c = x;  s = y;  end
      2'd1: begin c = -y; s = x;  end
      2'd2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
  endfunction

  function automatic logic [29:0] vector_angle(input longint xi, input longint yi);
    longint x, y, z, nx, m;
    x = xi;
    y = yi;
    z = 0;
    if (x == 0 && y == 0) return '0;
    if (x < 0) begin
      x = -x; y = -y; z = 64'sh2000_0000;
    end
    // normalise up to 2^30 before vectoring
    forever begin
      m = (y < 0) ? -y : y;
      if (x > m) m = x;
      if (m >= (64'sd1 << 30)) break;
      x = x * 2;
      y = y * 2;
    end
    for (int i = 0; i < STAGES; i++) begin
      if (y < 0) begin
        nx = x - (y >>> i); y = y + (x >>> i); z = z - ATAN_STEP[i];
      end else begin
        nx = x + (y >>> i); y = y - (x >>> i); z = z + ATAN_STEP[i];
      end
      x = nx;
    end
    return z[29:0];
  endfunction

  function automatic bit inside_box(input longint x, input longint y);
    return x >= hi_half(box_lo_r) && x <= hi_half(box_hi_r) &&
           y >= lo_half(box_lo_r) && y <= lo_half(box_hi_r);
  endfunction

  function automatic out_item_t transform_element(input in_item_t it);
    out_item_t   r;
    longint      x, y, ox, oy, c, s, sxv, syv, px, py, ddx, ddy, dx, dy;
    longint      spx, spy, mx, my;
    longint unsigned lsq;
    logic [29:0] st, twice;
    logic [31:0] sw;
    x   = it.in_x;
    y   = it.in_y;
    ox  = x;
    oy  = y;
    st  = it.in_start_angle;
    sw  = it.in_sweep;
    sxv = hi_half(shift_r);
    syv = lo_half(shift_r);
    px  = hi_half(pivot_r);
    py  = lo_half(pivot_r);
    case (it.func)
      FUNC_TRANSLATE: begin
        ox = x + sxv;
        oy = y + syv;
      end
      FUNC_ROTATE: begin
        dx = x - px;
        dy = y - py;
        rotate_unit(turn_r, c, s);
        ox = px + scale_trig(dx, c) - scale_trig(dy, s);
        oy = py + scale_trig(dx, s) + scale_trig(dy, c);
        st = st + turn_r;
      end
      FUNC_MIRROR: begin
        ddx   = hi_half(axis_r);
        ddy   = lo_half(axis_r);
        lsq   = longint'(ddx * ddx) + longint'(ddy * ddy);
        twice = 30'({vector_angle(ddx, ddy), 1'b0});
        if (lsq > longint'(degen_r)) begin
          dx = x - px;
          dy = y - py;
          rotate_unit(twice, c, s);
          ox = px + scale_trig(dx, c) + scale_trig(dy, s);
          oy = py + scale_trig(dx, s) - scale_trig(dy, c);
        end
        st = twice - st;
        sw = -sw;
      end
      default: begin
        if (it.elem_kind == KIND_POINT) begin
          if (inside_box(x, y)) begin
            ox = x + sxv;
            oy = y + syv;
          end
        end else begin
          rotate_unit(st, c, s);
          spx = clamp32(x + scale_trig(longint'(it.in_radius), c));
          spy = clamp32(y + scale_trig(longint'(it.in_radius), s));
          if (inside_box(spx, spy)) begin
            mx = clamp32(spx + sxv);
            my = clamp32(spy + syv);
            if (mx != spx || my != spy) st = vector_angle(mx - x, my - y);
          end
        end
      end
    endcase
    r.out_kind        = it.elem_kind;
    r.out_x           = clamp32(ox);
    r.out_y           = clamp32(oy);
    r.out_radius      = (it.elem_kind == KIND_POINT) ? '0 : it.in_radius;
    r.out_start_angle = (it.elem_kind == KIND_POINT) ? '0 : st;
    r.out_sweep       = (it.elem_kind == KIND_POINT) ? '0 : sw;
    return r;
  endfunction

  always @(posedge clk) begin
    out_item_t got, want;
    if (!rst_n) begin
      shift_r      <= '0;
      pivot_r      <= '0;
      turn_r       <= '0;
      axis_r       <= AXIS_RESET;
      box_lo_r     <= '0;
      box_hi_r     <= '0;
      degen_r      <= 32'd1;
      outstanding  <= 0;
      fail_count   <= 0;
      results_seen <= 0;
      expected_q.delete();
    end else begin
      if (in_mon.valid && in_mon.ready) begin
        expected_q = {expected_q, transform_element(in_item_t'(in_mon.data))};
      end
      if (out_mon.valid && out_mon.ready) begin
        got = out_item_t'(out_mon.data);
        results_seen <= results_seen + 1;
        if (expected_q.size() == 0) begin
          if (fail_count < 10)
            $display("%0t: result with nothing outstanding: %h", $realtime, got);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_q.pop_front();
          if (got.out_kind != want.out_kind || got.out_x != want.out_x ||
              got.out_y != want.out_y || got.out_radius != want.out_radius ||
              got.out_start_angle != want.out_start_angle ||
              got.out_sweep != want.out_sweep) begin
            if (fail_count < 10)
              $display({"%0t: mismatch exp kind=%0d x=%h y=%h r=%h st=%h sw=%h",
                        " got kind=%0d x=%h y=%h r=%h st=%h sw=%h"}, $realtime,
                       want.out_kind, want.out_x, want.out_y, want.out_radius,
                       want.out_start_angle, want.out_sweep,
                       got.out_kind, got.out_x, got.out_y, got.out_radius,
                       got.out_start_angle, got.out_sweep);
            fail_count <= fail_count + 1;
          end
        end
      end
      outstanding <= expected_q.size();
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_SHIFT:  shift_r  <= cfg_data;
          CFG_PIVOT:  pivot_r  <= cfg_data;
          CFG_TURN:   turn_r   <= cfg_data[29:0];
          CFG_AXIS:   axis_r   <= cfg_data;
          CFG_BOX_LO: box_lo_r <= cfg_data;
          CFG_BOX_HI: box_hi_r <= cfg_data;
          CFG_DEGEN:  degen_r  <= cfg_data[31:0];
          default: ;
        endcase
      end
    end
  end

endmodule

// ----- sim/planar_point_arc_transform_test.sv -----
`timescale 1ns / 100ps

module planar_point_arc_transform_test;
  import pat_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_WAIT  = 100;
  localparam int PHASES      = 9;
  localparam int PER_PHASE   = 120;
  localparam int ONE_Q16     = 32'h0001_0000;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [63:0] cfg_data;
  int          outstanding, fail_count, results_seen;
  int          cycles;
  int          sent;
  bit          tx_noise, rx_noise;

  pat_stream_if #(.payload_t(in_item_t))  in_ch ();
  pat_stream_if #(.payload_t(out_item_t)) out_ch ();

  planar_point_arc_transform dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_s      (in_ch.sink),
    .out_s     (out_ch.source),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  pat_transform_checker checker_i (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_mon       (in_ch),
    .out_mon      (out_ch),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .outstanding  (outstanding),
    .fail_count   (fail_count),
    .results_seen (results_seen)
  );

  always begin
    clk = 1'b1; #4;
    clk = 1'b0; #4;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("planar_point_arc_transform test failed");
      $finish;
    end
  end

  // result side back-pressure
  initial begin
    out_ch.ready = 1'b1;
    forever begin
      @(negedge clk);
      if (rx_noise && $urandom_range(0, 9) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(negedge clk);
        out_ch.ready <= 1'b1;
      end
    end
  end

  task automatic cfg_write(input cfg_idx_t idx, input logic [63:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // called at a falling edge; returns at a falling edge
  task automatic send(input in_item_t it);
    in_ch.data  <= it;
    in_ch.valid <= 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    sent++;
    if (tx_noise && $urandom_range(0, 7) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
  endtask

  // called at a falling edge, straight after the last send
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
  endtask

  function automatic in_item_t element(input func_t f, input logic k,
                                       input logic [31:0] x, input logic [31:0] y,
                                       input logic [30:0] r, input logic [29:0] st,
                                       input logic [31:0] sw);
    in_item_t it;
    it.func = f; it.elem_kind = k; it.in_x = x; it.in_y = y;
    it.in_radius = r; it.in_start_angle = st; it.in_sweep = sw;
    return it;
  endfunction

  function automatic logic [31:0] near_coord();
    return (32'($urandom_range(0, 32'h0100_0000)) - 32'h0080_0000);
  endfunction

  function automatic logic [31:0] any_coord();
    return ($urandom_range(0, 3) == 0) ? $urandom : near_coord();
  endfunction

  function automatic in_item_t random_element();
    in_item_t it;
    it.func           = func_t'($urandom_range(0, 3));
    it.elem_kind      = 1'($urandom_range(0, 1));
    it.in_x           = any_coord();
    it.in_y           = any_coord();
    it.in_radius      = ($urandom_range(0, 4) == 0) ? 31'($urandom)
                                                    : 31'($urandom_range(0, 32'h0040_0000));
    it.in_start_angle = 30'($urandom);
    it.in_sweep       = ($urandom_range(0, 4) == 0) ? $urandom
                          : 32'($urandom_range(0, 32'h8000_0000)) - 32'h4000_0000;
    return it;
  endfunction

  task automatic random_settings(input int phase);
    logic [31:0] a, b;
    case (phase)
      0: begin
        cfg_write(CFG_SHIFT, '0);  cfg_write(CFG_PIVOT, '0);
        cfg_write(CFG_TURN, '0);   cfg_write(CFG_AXIS, '0);
        cfg_write(CFG_BOX_LO, '0); cfg_write(CFG_BOX_HI, '0);
        cfg_write(CFG_DEGEN, '0);
      end
      1: begin
        cfg_write(CFG_SHIFT, '1);  cfg_write(CFG_PIVOT, '1);
        cfg_write(CFG_TURN, '1);   cfg_write(CFG_AXIS, '1);
        cfg_write(CFG_BOX_LO, {32'h8000_0000, 32'h8000_0000});
        cfg_write(CFG_BOX_HI, {32'h7fff_ffff, 32'h7fff_ffff});
        cfg_write(CFG_DEGEN, '1);
      end
      default: begin
        cfg_write(CFG_SHIFT, (phase % 3 == 0) ? {$urandom, $urandom}
                                             : {near_coord(), near_coord()});
        cfg_write(CFG_PIVOT, {near_coord(), near_coord()});
        cfg_write(CFG_TURN, {34'd0, 30'($urandom)});
        cfg_write(CFG_AXIS, (phase % 4 == 0) ? {$urandom, $urandom}
                                            : {near_coord(), near_coord()});
        a = $urandom_range(0, 32'h0080_0000);
        b = $urandom_range(0, 32'h0080_0000);
        cfg_write(CFG_BOX_LO, {-a, -b});
        if (phase == 5) cfg_write(CFG_BOX_HI, {-a - 32'd1, b});  // empty in x
        else            cfg_write(CFG_BOX_HI, {a, b});
        cfg_write(CFG_DEGEN, (phase % 2 == 0) ? 64'($urandom)
                                             : 64'($urandom_range(0, 1000)));
      end
    endcase
  endtask

  initial begin
    rst_n       = 1'b0;
    cfg_we      = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    in_ch.valid = 1'b0;
    in_ch.data  = '0;
    sent        = 0;
    tx_noise    = 1'b0;
    rx_noise    = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // defaults after reset: unit axis, empty-ish box at origin
    @(negedge clk);
    send(element(FUNC_TRANSLATE, KIND_POINT, 32'h7fff_ffff, 32'h8000_0000, '1, '1, '1));
    send(element(FUNC_MIRROR, KIND_ARC, 32'h0003_0000, 32'hfffe_0000, 31'h10000,
                 30'h0100_0000, 32'h4000_0000));
    send(element(FUNC_STRETCH, KIND_POINT, 32'h0, 32'h0, '0, '0, '0));
    drain();

    // saturating shift, full turn minus one, zero axis (degenerate mirror)
    cfg_write(CFG_SHIFT, {32'h7fff_ffff, 32'h8000_0000});
    cfg_write(CFG_PIVOT, {32'h0001_0000, 32'hffff_0000});
    cfg_write(CFG_TURN, 64'h3fff_ffff);
    cfg_write(CFG_AXIS, '0);
    cfg_write(CFG_DEGEN, '0);
    cfg_write(CFG_BOX_LO, {-32'(100 * ONE_Q16), -32'(100 * ONE_Q16)});
    cfg_write(CFG_BOX_HI, {32'(100 * ONE_Q16), 32'(100 * ONE_Q16)});
    @(negedge clk);
    send(element(FUNC_TRANSLATE, KIND_POINT, 32'h7fff_ffff, 32'h8000_0000, '0, '0, '0));
    send(element(FUNC_TRANSLATE, KIND_ARC, 32'h8000_0000, 32'h7fff_ffff, '1, '1,
                 32'h8000_0000));
    send(element(FUNC_ROTATE, KIND_POINT, 32'h7fff_ffff, 32'h7fff_ffff, '0, '0, '0));
    send(element(FUNC_ROTATE, KIND_ARC, 32'h8000_0000, 32'h8000_0000, '1, '1,
                 32'hc000_0000));
    send(element(FUNC_MIRROR, KIND_POINT, 32'h1234_5678, 32'h8765_4321, '0, '0, '0));
    send(element(FUNC_MIRROR, KIND_ARC, 32'h0, 32'h0, 31'h1, 30'h1, 32'h8000_0000));
    send(element(FUNC_STRETCH, KIND_POINT, 32'(50 * ONE_Q16), 32'(-100 * ONE_Q16),
                 '0, '0, '0));
    send(element(FUNC_STRETCH, KIND_POINT, 32'(101 * ONE_Q16), 32'h0, '0, '0, '0));
    send(element(FUNC_STRETCH, KIND_ARC, 32'h0, 32'h0, 31'(10 * ONE_Q16),
                 30'h0400_0000, 32'h1000_0000));
    send(element(FUNC_STRETCH, KIND_ARC, 32'(200 * ONE_Q16), 32'h0,
                 31'(150 * ONE_Q16), 30'h2000_0000, 32'h0));
    drain();

    // diagonal axis, huge limit, empty box, zero shift on stretch
    cfg_write(CFG_AXIS, {32'h0001_0000, 32'h0001_0000});
    cfg_write(CFG_DEGEN, 64'hffff_ffff);
    cfg_write(CFG_BOX_LO, {32'(5 * ONE_Q16), 32'h0});
    cfg_write(CFG_BOX_HI, {32'(-5 * ONE_Q16), 32'h0});
    cfg_write(CFG_SHIFT, '0);
    @(negedge clk);
    send(element(FUNC_MIRROR, KIND_POINT, 32'(3 * ONE_Q16), 32'h0, '0, '0, '0));
    send(element(FUNC_MIRROR, KIND_ARC, 32'h7fff_ffff, 32'h8000_0000, '1, 30'h3fff_ffff,
                 32'h7fff_ffff));
    send(element(FUNC_STRETCH, KIND_POINT, 32'h0, 32'h0, '0, '0, '0));
    send(element(FUNC_STRETCH, KIND_ARC, 32'h0, 32'h0, '0, 30'h1000_0000, 32'h1));
    send(element(FUNC_ROTATE, KIND_ARC, 32'h0, 32'h0, '0, '0, 32'hbfff_ffff));
    drain();

    for (int p = 0; p < PHASES; p++) begin
      random_settings(p);
      tx_noise = (p < PHASES - 1) && (p % 3 != 2);
      rx_noise = (p < PHASES - 1) && (p % 3 != 1);
      @(negedge clk);
      for (int i = 0; i < PER_PHASE; i++) begin
        send(random_element());
        // hold off mid-phase until everything in flight has come back
        if (p == 3 && i == PER_PHASE / 2) begin
          in_ch.valid <= 1'b0;
          while (outstanding != 0) @(negedge clk);
        end
      end
      drain();
    end

    $display("Sent %0d elements and checked %0d results (points and arcs, all four",
             sent, results_seen);
    $display("operations) over %0d settings, with saturation, degenerate mirror axes",
             PHASES + 3);
    $display("and empty stretch boxes.");
    if (fail_count == 0 && outstanding == 0 && results_seen == sent) begin
      $display("planar_point_arc_transform test passed");
    end else begin
      $display("planar_point_arc_transform test failed");
    end
    $finish;
  end

endmodule
